FILE: hdl/rlmtf_pkg.sv
// ----------------------------------------------------------------------------
// rlmtf_pkg
// Shared types for the recency list: operation, status, sequencer state and
// the per-cell command.
// ----------------------------------------------------------------------------
package rlmtf_pkg;

    typedef enum logic [1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_BACK  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_FIND_MTF   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_SCAN   = 2'd2,
        S_COMMIT = 2'd3
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_SHIFT_BACK = 3'd1,
        CELL_SHIFT_FWD  = 3'd2,
        CELL_APPEND     = 3'd3,
        CELL_COMPARE    = 3'd4,
        CELL_SCAN       = 3'd5,
        CELL_MTF        = 3'd6
    } cell_op_t;

endpackage

FILE: hdl/rlmtf_cell.sv
// ----------------------------------------------------------------------------
// rlmtf_cell
// One list position: page, valid bit, match bit and the "match seen ahead"
// bit that ripples one position per cycle toward the back.
// ----------------------------------------------------------------------------
module rlmtf_cell #(
    parameter int PAGE_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rlmtf_pkg::cell_op_t     op,
    input  logic [PAGE_BITS-1:0]    key,
    input  logic [PAGE_BITS-1:0]    prev_data,
    input  logic                    prev_valid,
    input  logic                    prev_flag,
    input  logic [PAGE_BITS-1:0]    next_data,
    input  logic                    next_valid,
    output logic [PAGE_BITS-1:0]    data,
    output logic                    valid,
    output logic                    flag
);

    logic [PAGE_BITS-1:0] data_reg, data_next;
    logic                 valid_reg, valid_next;
    logic                 match_reg, match_next;
    logic                 seen_reg, seen_next;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        seen_next  = seen_reg;
        unique case (op)
            rlmtf_pkg::CELL_HOLD: begin
            end
            rlmtf_pkg::CELL_SHIFT_BACK: begin
                data_next  = prev_data;
                valid_next = prev_valid;
            end
            rlmtf_pkg::CELL_SHIFT_FWD: begin
                data_next  = next_data;
                valid_next = next_valid;
            end
            rlmtf_pkg::CELL_APPEND: begin
                if (prev_valid && !valid_reg) begin
                    data_next  = key;
                    valid_next = 1'b1;
                end
            end
            rlmtf_pkg::CELL_COMPARE: begin
                match_next = valid_reg && (data_reg == key);
                seen_next  = 1'b0;
            end
            rlmtf_pkg::CELL_SCAN: begin
                seen_next = prev_flag;
            end
            rlmtf_pkg::CELL_MTF: begin
                if (!seen_reg) begin
                    data_next = prev_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            seen_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign flag  = seen_reg || match_reg;

endmodule

FILE: hdl/recency_list_move_to_front.sv
// ----------------------------------------------------------------------------
// recency_list_move_to_front
// LRU recency list with push front, push back, pop front and find with
// move to front, held in a chain of DEPTH cells.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                 tuser
// s_       in   page[15:0]            func[1:0]
// m_       out  page_out[15:0],       status[1:0]
//               occupancy[20:16]
//
// Push and pop accept the item, then, once the result port is free, push front
// and pop shift the chain and push back fills the first empty cell. Find
// compares in every cell, then the first-match mark ripples one cell per cycle
// down the chain, then a commit step moves the hit to the front.
// Reset empties the list at once. A new item is taken while a result waits;
// a stalled result holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module recency_list_move_to_front #(
    parameter int DEPTH     = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // page[15:0]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // page_out[15:0], occupancy[20:16]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SCAN_LAST = (DEPTH > 1) ? DEPTH - 2 : 0;

    rlmtf_pkg::state_t   state_reg, state_next;
    rlmtf_pkg::func_t    func_reg, func_next;
    logic [PAGE_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [15:0]         page_out_reg, page_out_next;
    rlmtf_pkg::status_t  status_reg, status_next;
    logic [4:0]          occ_reg, occ_next;

    rlmtf_pkg::cell_op_t  cell_op;
    logic [PAGE_BITS-1:0] cell_data  [DEPTH];
    logic                 cell_valid [DEPTH];
    logic                 cell_flag  [DEPTH];

    logic [PAGE_BITS+15:0] key_ext;
    logic [PAGE_BITS+15:0] front_ext;
    logic [CNT_W+4:0]      occ_ext;
    logic                  out_free;
    logic                  full;
    logic                  empty;
    logic                  hit;

    assign key_ext   = {{PAGE_BITS{1'b0}}, s_tdata};
    assign front_ext = {16'd0, cell_data[0]};
    assign out_free  = !m_tvalid_reg || m_tready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign hit       = cell_flag[DEPTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [PAGE_BITS-1:0] prev_data;
            logic                 prev_valid;
            logic                 prev_flag;
            logic [PAGE_BITS-1:0] next_data;
            logic                 next_valid;

            if (gi == 0) begin : g_head
                assign prev_data  = key_reg;
                assign prev_valid = 1'b1;
                assign prev_flag  = 1'b0;
            end else begin : g_body
                assign prev_data  = cell_data[gi-1];
                assign prev_valid = cell_valid[gi-1];
                assign prev_flag  = cell_flag[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign next_data  = '0;
                assign next_valid = 1'b0;
            end else begin : g_inner
                assign next_data  = cell_data[gi+1];
                assign next_valid = cell_valid[gi+1];
            end

            rlmtf_cell #(
                .PAGE_BITS(PAGE_BITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .op        (cell_op),
                .key       (key_reg),
                .prev_data (prev_data),
                .prev_valid(prev_valid),
                .prev_flag (prev_flag),
                .next_data (next_data),
                .next_valid(next_valid),
                .data      (cell_data[gi]),
                .valid     (cell_valid[gi]),
                .flag      (cell_flag[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        page_out_next = page_out_reg;
        status_next   = status_reg;
        cell_op       = rlmtf_pkg::CELL_HOLD;
        s_tready      = (state_reg == rlmtf_pkg::S_IDLE);

        unique case (state_reg)
            rlmtf_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    func_next  = rlmtf_pkg::func_t'(s_tuser);
                    key_next   = key_ext[PAGE_BITS-1:0];
                    state_next = rlmtf_pkg::S_EXEC;
                end
            end
            rlmtf_pkg::S_EXEC: begin
                if (func_reg == rlmtf_pkg::FUNC_FIND_MTF) begin
                    cell_op    = rlmtf_pkg::CELL_COMPARE;
                    scan_next  = '0;
                    state_next = rlmtf_pkg::S_SCAN;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    page_out_next = '0;
                    status_next   = rlmtf_pkg::ST_OK;
                    state_next    = rlmtf_pkg::S_IDLE;
                    unique case (func_reg)
                        rlmtf_pkg::FUNC_PUSH_FRONT: begin
                            if (full) begin
                                status_next = rlmtf_pkg::ST_FULL;
                            end else begin
                                cell_op    = rlmtf_pkg::CELL_SHIFT_BACK;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        rlmtf_pkg::FUNC_PUSH_BACK: begin
                            if (full) begin
                                status_next = rlmtf_pkg::ST_FULL;
                            end else begin
                                cell_op    = rlmtf_pkg::CELL_APPEND;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        rlmtf_pkg::FUNC_POP_FRONT: begin
                            if (empty) begin
                                status_next = rlmtf_pkg::ST_EMPTY;
                            end else begin
                                cell_op       = rlmtf_pkg::CELL_SHIFT_FWD;
                                page_out_next = front_ext[15:0];
                                count_next    = count_reg - CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rlmtf_pkg::S_SCAN: begin
                cell_op = rlmtf_pkg::CELL_SCAN;
                if (scan_reg == CNT_W'(SCAN_LAST)) begin
                    state_next = rlmtf_pkg::S_COMMIT;
                end else begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            rlmtf_pkg::S_COMMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    page_out_next = '0;
                    state_next    = rlmtf_pkg::S_IDLE;
                    if (hit) begin
                        cell_op     = rlmtf_pkg::CELL_MTF;
                        status_next = rlmtf_pkg::ST_OK;
                    end else begin
                        status_next = rlmtf_pkg::ST_MISS;
                    end
                end
            end
            default: begin
                state_next = rlmtf_pkg::S_IDLE;
            end
        endcase
    end

    assign occ_ext  = {5'd0, count_next};
    assign occ_next = (m_tvalid_next && !(m_tvalid_reg && !m_tready)) ? occ_ext[4:0] : occ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rlmtf_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        scan_reg     <= scan_next;
        page_out_reg <= page_out_next;
        status_reg   <= status_next;
        occ_reg      <= occ_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, occ_reg, page_out_reg};
    assign m_tuser  = status_reg;

endmodule

FILE: hdl/rlmtf_checker.sv
// ----------------------------------------------------------------------------
// rlmtf_checker
// Port-level checks on the recency list, bound to the top level.
// ----------------------------------------------------------------------------
module rlmtf_checker #(
    parameter int DEPTH = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    localparam logic [4:0] FULL_OCC = 5'(DEPTH);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous beat still in work");

    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == rlmtf_pkg::ST_EMPTY) |->
            (m_tdata[20:16] == 5'd0) && (m_tdata[15:0] == 16'd0))
        else $error("empty status with nonzero page or occupancy");

    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == rlmtf_pkg::ST_FULL) |->
            (m_tdata[20:16] == FULL_OCC) && (m_tdata[15:0] == 16'd0))
        else $error("full status with wrong occupancy or page");

    a_miss_page: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == rlmtf_pkg::ST_MISS) |-> (m_tdata[15:0] == 16'd0))
        else $error("miss status with nonzero page");

endmodule

bind recency_list_move_to_front rlmtf_checker #(
    .DEPTH(DEPTH)
) u_rlmtf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
